// ===== src/xy_linear_interpolator_assert.svh =====
// Assertion macros shared by the interpolator RTL.
`ifndef XY_LINEAR_INTERPOLATOR_ASSERT_SVH
`define XY_LINEAR_INTERPOLATOR_ASSERT_SVH

// Check that a condition implies a consequence in the same cycle.
`define XYLI_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("interpolator check failed in the same cycle");

// Check that a condition implies a consequence in the following cycle.
`define XYLI_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("interpolator check failed one cycle later");

`endif

// ===== src/xyli_pkg.sv =====
// Shared types, widths and codes of the two-axis linear interpolator.
`timescale 1ns / 1ps

package xyli_pkg;

  // Position and field widths
  localparam int POS_BITS   = 16;
  localparam int COORD_BITS = 16;
  localparam int FEED_BITS  = 12;
  localparam int KIND_BITS  = 2;
  localparam int IDX_BITS   = 3;
  localparam int WDATA_BITS = 16;

  localparam int S_TDATA_BITS = COORD_BITS;
  localparam int M_TDATA_BITS = 2 * COORD_BITS;
  localparam int M_TUSER_BITS = 2;

  // Feed handling: dD = feed / 6 as a reciprocal multiply
  localparam logic [FEED_BITS-1:0] FEED_MIN   = FEED_BITS'(6);
  localparam logic [FEED_BITS-1:0] FEED_RECIP = FEED_BITS'(2731);
  localparam int FEED_SHIFT = 14;
  localparam int DD_BITS    = 10;

  // Serial arithmetic widths
  localparam int SQ_BITS    = 2 * POS_BITS + 2;
  localparam int ROOT_BITS  = POS_BITS + 1;
  localparam int REM_BITS   = ROOT_BITS + 3;
  localparam int DIV_BITS   = POS_BITS + 2;
  localparam int ROOT_CNT_BITS = $clog2(ROOT_BITS + 1);
  localparam int DIV_CNT_BITS  = $clog2(DIV_BITS + 1);

  // Register indexes of the configuration port
  localparam logic [IDX_BITS-1:0] REG_X_LO      = 3'd0;
  localparam logic [IDX_BITS-1:0] REG_X_HI      = 3'd1;
  localparam logic [IDX_BITS-1:0] REG_Y_LO      = 3'd2;
  localparam logic [IDX_BITS-1:0] REG_Y_HI      = 3'd3;
  localparam logic [IDX_BITS-1:0] REG_CUT_RATE  = 3'd4;
  localparam logic [IDX_BITS-1:0] REG_TRAV_RATE = 3'd5;
  localparam logic [IDX_BITS-1:0] REG_USE_TRAV  = 3'd6;

  // Request kinds
  localparam logic [KIND_BITS-1:0] KIND_TICK  = 2'd0;
  localparam logic [KIND_BITS-1:0] KIND_SET_X = 2'd1;
  localparam logic [KIND_BITS-1:0] KIND_SET_Y = 2'd2;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [POS_BITS-1:0]   pos_t;

  typedef struct packed {
    coord_t               x_lo;
    coord_t               x_hi;
    coord_t               y_lo;
    coord_t               y_hi;
    logic [FEED_BITS-1:0] cut_rate;
    logic [FEED_BITS-1:0] trav_rate;
    logic                 use_trav;
  } cfg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_SUM,
    ST_ROOT_GO,
    ST_ROOT,
    ST_STEPS_GO,
    ST_STEPS,
    ST_AXIS_GO,
    ST_AXIS,
    ST_DONE
  } state_t;

endpackage

// ===== src/xyli_cfg.sv =====
// Configuration registers of the interpolator with feed saturation.
`timescale 1ns / 1ps

module xyli_cfg (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            wr_en,
  input  logic [xyli_pkg::IDX_BITS-1:0]   wr_index,
  input  logic [xyli_pkg::WDATA_BITS-1:0] wr_data,
  output xyli_pkg::cfg_t                  cfg
);
  import xyli_pkg::*;

  logic [FEED_BITS-1:0] feed_in;
  logic [FEED_BITS-1:0] feed_sat;

  // Raise feeds below the minimum so dD never becomes zero
  assign feed_in  = wr_data[FEED_BITS-1:0];
  assign feed_sat = (feed_in < FEED_MIN) ? FEED_MIN : feed_in;

  // Store a write at its index, ignore unknown indexes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.x_lo      <= COORD_BITS'(0);
      cfg.x_hi      <= COORD_BITS'(4000);
      cfg.y_lo      <= COORD_BITS'(0);
      cfg.y_hi      <= COORD_BITS'(4000);
      cfg.cut_rate  <= FEED_BITS'(180);
      cfg.trav_rate <= FEED_BITS'(600);
      cfg.use_trav  <= 1'b0;
    end else if (wr_en) begin
      case (wr_index)
        REG_X_LO:      cfg.x_lo      <= wr_data[COORD_BITS-1:0];
        REG_X_HI:      cfg.x_hi      <= wr_data[COORD_BITS-1:0];
        REG_Y_LO:      cfg.y_lo      <= wr_data[COORD_BITS-1:0];
        REG_Y_HI:      cfg.y_hi      <= wr_data[COORD_BITS-1:0];
        REG_CUT_RATE:  cfg.cut_rate  <= feed_sat;
        REG_TRAV_RATE: cfg.trav_rate <= feed_sat;
        REG_USE_TRAV:  cfg.use_trav  <= wr_data[0];
        default: ;
      endcase
    end
  end

endmodule

// ===== src/xyli_sqrt.sv =====
// Digit-serial integer square root, one root bit per cycle.
`timescale 1ns / 1ps

module xyli_sqrt (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [xyli_pkg::SQ_BITS-1:0]   radicand,
  output logic                           done,
  output logic [xyli_pkg::ROOT_BITS-1:0] root
);
  import xyli_pkg::*;

  logic [SQ_BITS-1:0]       val;
  logic [REM_BITS-1:0]      rem;
  logic [ROOT_CNT_BITS-1:0] cnt;
  logic [REM_BITS-1:0]      rem_sh;
  logic [REM_BITS-1:0]      trial;
  logic                     fits;

  // Bring down the next two radicand bits and try root*4+1
  assign rem_sh = {rem[REM_BITS-3:0], val[SQ_BITS-1 -: 2]};
  assign trial  = REM_BITS'({root, 2'b01});
  assign fits   = (rem_sh >= trial);

  // Control: count the iterations, flag the last one
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else if (start) begin
      cnt  <= ROOT_CNT_BITS'(ROOT_BITS);
      done <= 1'b0;
    end else begin
      done <= (cnt == ROOT_CNT_BITS'(1));
      if (cnt != '0) begin
        cnt <= cnt - ROOT_CNT_BITS'(1);
      end
    end
  end

  // Datapath: shift the radicand, update remainder and root
  always_ff @(posedge clk) begin
    if (start) begin
      val  <= radicand;
      rem  <= '0;
      root <= '0;
    end else if (cnt != '0) begin
      val  <= {val[SQ_BITS-3:0], 2'b00};
      rem  <= fits ? (rem_sh - trial) : rem_sh;
      root <= {root[ROOT_BITS-2:0], fits};
    end
  end

endmodule

// ===== src/xyli_div.sv =====
// Digit-serial restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module xyli_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [xyli_pkg::DIV_BITS-1:0] dividend,
  input  logic [xyli_pkg::DIV_BITS-1:0] divisor,
  output logic                          done,
  output logic [xyli_pkg::DIV_BITS-1:0] quotient
);
  import xyli_pkg::*;

  logic [DIV_BITS-1:0]     dvs;
  logic [DIV_BITS:0]       rem;
  logic [DIV_CNT_BITS-1:0] cnt;
  logic [DIV_BITS:0]       rem_sh;
  logic                    fits;

  // Shift the next dividend bit into the partial remainder
  assign rem_sh = {rem[DIV_BITS-1:0], quotient[DIV_BITS-1]};
  assign fits   = (rem_sh >= {1'b0, dvs});

  // Control: count the iterations, flag the last one
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else if (start) begin
      cnt  <= DIV_CNT_BITS'(DIV_BITS);
      done <= 1'b0;
    end else begin
      done <= (cnt == DIV_CNT_BITS'(1));
      if (cnt != '0) begin
        cnt <= cnt - DIV_CNT_BITS'(1);
      end
    end
  end

  // Datapath: the quotient register doubles as the dividend shifter
  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      dvs      <= divisor;
      rem      <= '0;
    end else if (cnt != '0) begin
      rem      <= fits ? (rem_sh - {1'b0, dvs}) : rem_sh;
      quotient <= {quotient[DIV_BITS-2:0], fits};
    end
  end

endmodule

// ===== src/xy_linear_interpolator.sv =====
// Top level of the two-axis linear interpolator.
//
// Usage: requests enter on the s_ stream, one at a time. s_tuser carries the kind
// (tick, set X goal, set Y goal), s_tdata the target coordinate. A set request
// clamps the coordinate to the axis limits and stores it as that axis's goal. A
// tick moves the position one step toward the goal. Every request yields exactly
// one result on the m_ stream: the position and the moving and arrived flags.
// Configuration writes use wr_en, wr_index and wr_data while no request is open;
// the user must keep to this, as the block does not enforce it. A set request, an
// unused kind or a tick with no distance left goes from idle to the done state,
// which loads the output register. A tick that moves runs the square, sum and root
// start states, the square-root iterations and the step-count division; one that
// snaps then goes to done, else both axis divisions run in parallel to set the step.
// A new request is taken the cycle after the previous one reaches the output
// register. A receiver stall holds the result in the output register; the next
// request is still accepted and computed, and waits in the done state until the
// register frees. Reset restores the default limits and feeds, sets position and
// goals to zero, clears the motion flag and empties the output register.
`timescale 1ns / 1ps

module xy_linear_interpolator (
  input  logic                              clk,
  input  logic                              rst,
  // Request stream
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [xyli_pkg::S_TDATA_BITS-1:0] s_tdata,  // [15:0] target_value
  input  logic [xyli_pkg::KIND_BITS-1:0]    s_tuser,  // [1:0] kind
  // Result stream
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [xyli_pkg::M_TDATA_BITS-1:0] m_tdata,  // [15:0] pos_x, [31:16] pos_y
  output logic [xyli_pkg::M_TUSER_BITS-1:0] m_tuser,  // [0] moving, [1] arrived
  // Configuration write port
  input  logic                              wr_en,
  input  logic [xyli_pkg::IDX_BITS-1:0]     wr_index,
  input  logic [xyli_pkg::WDATA_BITS-1:0]   wr_data
);
  import xyli_pkg::*;

  `include "xy_linear_interpolator_assert.svh"

  cfg_t   cfg;
  state_t state;
  state_t state_next;

  // Block state
  pos_t cur_x;
  pos_t cur_y;
  pos_t goal_x;
  pos_t goal_y;
  logic in_motion;
  logic arrived;

  // Datapath registers of a moving tick
  logic [POS_BITS-1:0]   ax;
  logic [POS_BITS-1:0]   ay;
  logic                  up_x;
  logic                  up_y;
  logic [2*POS_BITS-1:0] sq_x;
  logic [2*POS_BITS-1:0] sq_y;
  logic [SQ_BITS-1:0]    rad;
  logic [DD_BITS-1:0]    dd;
  logic [DIV_BITS-1:0]   n_steps;

  // Control and arithmetic unit signals
  logic                          accept;
  logic                          has_diff;
  logic                          out_load;
  logic                          sqrt_start;
  logic                          sqrt_done;
  logic [ROOT_BITS-1:0]          root;
  logic                          div_a_start;
  logic                          div_b_start;
  logic                          div_a_done;
  logic                          div_b_done;
  logic [DIV_BITS-1:0]           div_a_dvd;
  logic [DIV_BITS-1:0]           div_a_dvs;
  logic [DIV_BITS-1:0]           qa;
  logic [DIV_BITS-1:0]           qb;
  logic [DIV_BITS-1:0]           num;
  logic [DIV_BITS-1:0]           den;
  logic                          snap;
  logic [POS_BITS:0]             dx;
  logic [POS_BITS:0]             dy;
  logic [POS_BITS:0]             neg_dx;
  logic [POS_BITS:0]             neg_dy;
  coord_t                        tv;
  coord_t                        clamp_x;
  coord_t                        clamp_y;
  logic [FEED_BITS-1:0]          feed;
  logic [2*FEED_BITS-1:0]        feed_prod;

  xyli_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .cfg      (cfg)
  );

  xyli_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sqrt_start),
    .radicand (rad),
    .done     (sqrt_done),
    .root     (root)
  );

  // Divider A: step count first, then the X step
  xyli_div u_div_a (
    .clk      (clk),
    .rst      (rst),
    .start    (div_a_start),
    .dividend (div_a_dvd),
    .divisor  (div_a_dvs),
    .done     (div_a_done),
    .quotient (qa)
  );

  // Divider B: the Y step
  xyli_div u_div_b (
    .clk      (clk),
    .rst      (rst),
    .start    (div_b_start),
    .dividend (DIV_BITS'(ay)),
    .divisor  (n_steps),
    .done     (div_b_done),
    .quotient (qb)
  );

  // Clamp the target to the high limit first, then to the low limit
  assign tv = s_tdata[COORD_BITS-1:0];

  always_comb begin
    clamp_x = tv;
    if (tv > cfg.x_hi) clamp_x = cfg.x_hi;
    if (tv < cfg.x_lo) clamp_x = cfg.x_lo;
    clamp_y = tv;
    if (tv > cfg.y_hi) clamp_y = cfg.y_hi;
    if (tv < cfg.y_lo) clamp_y = cfg.y_lo;
  end

  // Signed distance to the goal and its magnitude per axis
  assign dx     = {goal_x[POS_BITS-1], goal_x} - {cur_x[POS_BITS-1], cur_x};
  assign dy     = {goal_y[POS_BITS-1], goal_y} - {cur_y[POS_BITS-1], cur_y};
  assign neg_dx = -dx;
  assign neg_dy = -dy;
  assign has_diff = (cur_x != goal_x) || (cur_y != goal_y);

  // Travel per tick: feed / 6 through a reciprocal multiply
  assign feed      = cfg.use_trav ? cfg.trav_rate : cfg.cut_rate;
  assign feed_prod = feed * FEED_RECIP;

  // Step count n = (2D + dD) / (2dD), rounding to nearest
  assign num  = DIV_BITS'({root, 1'b0}) + DIV_BITS'(dd);
  assign den  = DIV_BITS'({dd, 1'b0});
  assign snap = (qa <= DIV_BITS'(1));

  assign div_a_dvd = (state == ST_STEPS_GO) ? num : DIV_BITS'(ax);
  assign div_a_dvs = (state == ST_STEPS_GO) ? den : n_steps;

  assign accept = s_tvalid && s_tready;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          if (s_tuser == KIND_TICK && has_diff) state_next = ST_SQUARE;
          else                                  state_next = ST_DONE;
        end
      end
      ST_SQUARE:   state_next = ST_SUM;
      ST_SUM:      state_next = ST_ROOT_GO;
      ST_ROOT_GO:  state_next = ST_ROOT;
      ST_ROOT:     if (sqrt_done) state_next = ST_STEPS_GO;
      ST_STEPS_GO: state_next = ST_STEPS;
      ST_STEPS: begin
        if (div_a_done) state_next = snap ? ST_DONE : ST_AXIS_GO;
      end
      ST_AXIS_GO:  state_next = ST_AXIS;
      ST_AXIS:     if (div_a_done) state_next = ST_DONE;
      ST_DONE:     if (!m_tvalid || m_tready) state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  // Control outputs of the sequencer
  always_comb begin
    s_tready    = (state == ST_IDLE);
    sqrt_start  = (state == ST_ROOT_GO);
    div_a_start = (state == ST_STEPS_GO) || (state == ST_AXIS_GO);
    div_b_start = (state == ST_AXIS_GO);
    out_load    = (state == ST_DONE) && (!m_tvalid || m_tready);
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // Update goals, position and motion flags
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_x     <= '0;
      cur_y     <= '0;
      goal_x    <= '0;
      goal_y    <= '0;
      in_motion <= 1'b0;
      arrived   <= 1'b0;
    end else if (accept) begin
      arrived <= 1'b0;
      unique case (s_tuser)
        KIND_SET_X: goal_x <= POS_BITS'(clamp_x);
        KIND_SET_Y: goal_y <= POS_BITS'(clamp_y);
        KIND_TICK:  if (!has_diff) in_motion <= 1'b0;
        default: ;
      endcase
    end else if (state == ST_STEPS && div_a_done && snap) begin
      cur_x     <= goal_x;
      cur_y     <= goal_y;
      in_motion <= 1'b0;
      arrived   <= 1'b1;
    end else if (state == ST_AXIS && div_a_done) begin
      cur_x     <= up_x ? cur_x + POS_BITS'(qa) : cur_x - POS_BITS'(qa);
      cur_y     <= up_y ? cur_y + POS_BITS'(qb) : cur_y - POS_BITS'(qb);
      in_motion <= 1'b1;
    end
  end

  // Capture magnitudes, squares, radicand, dD and step count
  always_ff @(posedge clk) begin
    if (accept) begin
      ax   <= dx[POS_BITS] ? neg_dx[POS_BITS-1:0] : dx[POS_BITS-1:0];
      ay   <= dy[POS_BITS] ? neg_dy[POS_BITS-1:0] : dy[POS_BITS-1:0];
      up_x <= ~dx[POS_BITS];
      up_y <= ~dy[POS_BITS];
    end
    if (state == ST_SQUARE) begin
      sq_x <= ax * ax;
      sq_y <= ay * ay;
    end
    if (state == ST_SUM) begin
      rad <= SQ_BITS'(sq_x) + SQ_BITS'(sq_y);
      dd  <= feed_prod[FEED_SHIFT +: DD_BITS];
    end
    if (state == ST_STEPS && div_a_done) begin
      n_steps <= qa;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {COORD_BITS'(cur_y), COORD_BITS'(cur_x)};
      m_tuser <= {arrived, in_motion};
    end
  end

  // Checks on sequencing and result flags
  `XYLI_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready)
  `XYLI_ASSERT_NOW(a_arrived_not_moving, m_tvalid && m_tuser[1], !m_tuser[0])
  `XYLI_ASSERT_NOW(a_axis_dividers_align, state == ST_AXIS && div_a_done, div_b_done)
  `XYLI_ASSERT_NOW(a_root_only_when_waited, sqrt_done, state == ST_ROOT)

endmodule
